// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Layout constants and shared types of the traceparent parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpp_pkg;

  // character offsets within the header
  localparam logic [5:0] DASH_POS_VER   = 6'd2;
  localparam logic [5:0] DASH_POS_TRACE = 6'd35;
  localparam logic [5:0] DASH_POS_SPAN  = 6'd52;
  localparam logic [5:0] HDR_LEN        = 6'd55;  // also the optional trailing dash
  localparam logic [5:0] FINAL_POS      = 6'd54;  // offset of last char of a bare header
  localparam logic [5:0] VER_LAST       = 6'd1;
  localparam logic [5:0] TRACE_FIRST    = 6'd3;
  localparam logic [5:0] TRACE_LAST     = 6'd34;
  localparam logic [5:0] SPAN_FIRST     = 6'd36;
  localparam logic [5:0] SPAN_LAST      = 6'd51;
  localparam logic [5:0] FLAG_FIRST     = 6'd53;
  localparam logic [5:0] FLAG_LAST      = 6'd54;
  localparam logic [5:0] POS_MAX        = 6'd63;

  // ASCII codes
  localparam logic [7:0] ASCII_DASH = 8'h2D;
  localparam logic [7:0] ASCII_0    = 8'h30;
  localparam logic [7:0] ASCII_9    = 8'h39;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_F = 8'h66;

  // version codes
  localparam logic [7:0] VERSION_ZERO    = 8'h00;
  localparam logic [7:0] VERSION_INVALID = 8'hFF;

  // per-character classification
  typedef struct packed {
    logic       is_dash;
    logic       is_hex;
    logic [3:0] nib;
    logic       at_dash;
    logic       at_version;
    logic       at_trace;
    logic       at_span;
    logic       at_flag;
  } char_class_t;

endpackage

// File: rtl/tpp_if.sv
// ----------------------------------------------------------------------------
// tpp_if
// Valid/ready channels: header characters in, parse results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, char_byte, last_char, input ready);
  modport sink   (input valid, char_byte, last_char, output ready);
endinterface

interface tpp_out_if;
  logic        valid;
  logic        ready;
  logic        header_valid;
  logic [7:0]  version_value;
  logic [63:0] trace_id_high;
  logic [63:0] trace_id_low;
  logic [63:0] parent_span;
  logic        sampled_bit;

  modport source (output valid, header_valid, version_value, trace_id_high,
                  trace_id_low, parent_span, sampled_bit, input ready);
  modport sink   (input valid, header_valid, version_value, trace_id_high,
                  trace_id_low, parent_span, sampled_bit, output ready);
endinterface

// File: rtl/traceparent_header_parser.sv
// ----------------------------------------------------------------------------
// traceparent_header_parser
// Streaming checker and field extractor for a trace-context header.
// ----------------------------------------------------------------------------
// Usage:
//   hdr_in carries one ASCII character per transfer, last_char set on the
//   final character of a header. Each header yields exactly one transfer on
//   res_out, issued for its last character: header_valid plus the version,
//   trace id, span id and sampled bit, all zero when the header fails.
//   Characters that are not last produce nothing.
// Timing:
//   One character per cycle sustained, apart from the stalls below. Each
//   character is first held in an input register, then checked against its
//   offset and folded into the shift registers; a last character's result
//   passes from the input register into the output register.
// Stalls:
//   The output register frees the input side: characters keep flowing while
//   a result waits. Only a last character stalls, and only while a previous
//   result still sits unread; hdr_in.ready then drops.
// Reset:
//   rst (synchronous) empties both registers and returns the parser to
//   offset zero, ready for the start of a header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module traceparent_header_parser (
  input  logic            clk,
  input  logic            rst,
  tpp_in_if.sink          hdr_in,
  tpp_out_if.source       res_out
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;

  // parse state
  logic [5:0]  char_position;
  logic        still_valid;
  logic [7:0]  version_shift;
  logic [63:0] trace_hi;
  logic [63:0] trace_lo;
  logic [63:0] span_shift;
  logic        trace_nonzero;
  logic        span_nonzero;
  logic [3:0]  flag_nibble;

  logic [5:0]  char_position_next;
  logic        still_valid_next;
  logic [7:0]  version_shift_next;
  logic [63:0] trace_hi_next;
  logic [63:0] trace_lo_next;
  logic [63:0] span_shift_next;
  logic        trace_nonzero_next;
  logic        span_nonzero_next;
  logic [3:0]  flag_nibble_next;

  // result register
  logic        out_valid;
  logic        out_header_valid;
  logic [7:0]  out_version;
  logic [63:0] out_trace_hi;
  logic [63:0] out_trace_lo;
  logic [63:0] out_span;
  logic        out_sampled;

  tpp_pkg::char_class_t cls;
  logic header_ok;
  logic out_free;
  logic s1_advance;
  logic s1_emit;

  // A non-last character never waits; a last one needs the output slot.
  assign out_free   = !out_valid || res_out.ready;
  assign s1_advance = s1_valid && (!s1_last || out_free);
  assign s1_emit    = s1_advance && s1_last;
  assign hdr_in.ready = !s1_valid || s1_advance;

  tpp_char_decode u_decode (
    .char_byte     (s1_char),
    .char_position (char_position),
    .cls           (cls)
  );

  // Fold the held character into the parse state.
  always_comb begin
    still_valid_next   = still_valid;
    version_shift_next = version_shift;
    trace_hi_next      = trace_hi;
    trace_lo_next      = trace_lo;
    span_shift_next    = span_shift;
    trace_nonzero_next = trace_nonzero;
    span_nonzero_next  = span_nonzero;
    flag_nibble_next   = flag_nibble;

    if (cls.at_dash) begin
      if (!cls.is_dash) still_valid_next = 1'b0;
    end else if (cls.at_version) begin
      if (!cls.is_hex) still_valid_next = 1'b0;
      version_shift_next = {version_shift[3:0], cls.nib};
    end else if (cls.at_trace) begin
      if (!cls.is_hex) still_valid_next = 1'b0;
      if (cls.nib != 4'd0) trace_nonzero_next = 1'b1;
      trace_hi_next = {trace_hi[59:0], trace_lo[63:60]};
      trace_lo_next = {trace_lo[59:0], cls.nib};
    end else if (cls.at_span) begin
      if (!cls.is_hex) still_valid_next = 1'b0;
      if (cls.nib != 4'd0) span_nonzero_next = 1'b1;
      span_shift_next = {span_shift[59:0], cls.nib};
    end else if (cls.at_flag) begin
      if (!cls.is_hex) still_valid_next = 1'b0;
      flag_nibble_next = cls.nib;
    end
    // offsets past the trailing dash are not checked

    char_position_next = (char_position == tpp_pkg::POS_MAX) ? char_position
                                                             : 6'(char_position + 6'd1);

    // Header complete at this character: judged on the updated state.
    header_ok = still_valid_next && (char_position >= tpp_pkg::FINAL_POS) &&
                (version_shift_next != tpp_pkg::VERSION_INVALID) &&
                trace_nonzero_next && span_nonzero_next &&
                !((version_shift_next == tpp_pkg::VERSION_ZERO) &&
                  (char_position != tpp_pkg::FINAL_POS));
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hdr_in.ready) begin
      s1_valid <= hdr_in.valid;
    end
    if (hdr_in.ready && hdr_in.valid) begin
      s1_char <= hdr_in.char_byte;
      s1_last <= hdr_in.last_char;
    end
  end

  // parse state; back to offset zero after each header
  always_ff @(posedge clk) begin
    if (rst || s1_emit) begin
      char_position <= '0;
      still_valid   <= 1'b1;
      version_shift <= '0;
      trace_hi      <= '0;
      trace_lo      <= '0;
      span_shift    <= '0;
      trace_nonzero <= 1'b0;
      span_nonzero  <= 1'b0;
      flag_nibble   <= '0;
    end else if (s1_advance) begin
      char_position <= char_position_next;
      still_valid   <= still_valid_next;
      version_shift <= version_shift_next;
      trace_hi      <= trace_hi_next;
      trace_lo      <= trace_lo_next;
      span_shift    <= span_shift_next;
      trace_nonzero <= trace_nonzero_next;
      span_nonzero  <= span_nonzero_next;
      flag_nibble   <= flag_nibble_next;
    end
  end

  // result register; a failed header reports all fields zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_emit) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_emit) begin
      out_header_valid <= header_ok;
      out_version      <= header_ok ? version_shift_next : '0;
      out_trace_hi     <= header_ok ? trace_hi_next : '0;
      out_trace_lo     <= header_ok ? trace_lo_next : '0;
      out_span         <= header_ok ? span_shift_next : '0;
      out_sampled      <= header_ok & flag_nibble_next[0];
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.header_valid  = out_header_valid;
  assign res_out.version_value = out_version;
  assign res_out.trace_id_high = out_trace_hi;
  assign res_out.trace_id_low  = out_trace_lo;
  assign res_out.parent_span   = out_span;
  assign res_out.sampled_bit   = out_sampled;

  // checks
  `ASSERT_IMP(a_fail_zero, clk, rst,
    out_valid && !out_header_valid,
    out_version == '0 && out_trace_hi == '0 && out_trace_lo == '0 &&
    out_span == '0 && !out_sampled,
    "failed header reported non-zero fields")
  `ASSERT_IMP(a_pass_fields, clk, rst,
    out_valid && out_header_valid,
    out_version != tpp_pkg::VERSION_INVALID && out_span != '0 &&
    (out_trace_hi != '0 || out_trace_lo != '0),
    "passed header breaks version or id rules")
  `ASSERT_NEXT(a_restart, clk, rst,
    s1_emit,
    char_position == '0 && still_valid && !trace_nonzero && !span_nonzero,
    "parser did not restart after a header")

endmodule

// File: rtl/tpp_char_decode.sv
// ----------------------------------------------------------------------------
// tpp_char_decode
// Hex decode of one character and classification of its header offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpp_char_decode (
  input  logic [7:0]          char_byte,
  input  logic [5:0]          char_position,
  output tpp_pkg::char_class_t cls
);

  always_comb begin
    cls = '0;
    cls.is_dash = (char_byte == tpp_pkg::ASCII_DASH);
    if (char_byte inside {[tpp_pkg::ASCII_0 : tpp_pkg::ASCII_9]}) begin
      cls.is_hex = 1'b1;
      cls.nib    = char_byte[3:0];
    end else if (char_byte inside {[tpp_pkg::ASCII_LC_A : tpp_pkg::ASCII_LC_F]}) begin
      cls.is_hex = 1'b1;
      cls.nib    = 4'(char_byte[3:0] + 4'd9);  // 'a' low nibble is 1
    end
    // non-hex leaves nib at zero

    cls.at_dash    = (char_position inside {tpp_pkg::DASH_POS_VER, tpp_pkg::DASH_POS_TRACE,
                                            tpp_pkg::DASH_POS_SPAN, tpp_pkg::HDR_LEN});
    cls.at_version = (char_position <= tpp_pkg::VER_LAST);
    cls.at_trace   = (char_position inside {[tpp_pkg::TRACE_FIRST : tpp_pkg::TRACE_LAST]});
    cls.at_span    = (char_position inside {[tpp_pkg::SPAN_FIRST : tpp_pkg::SPAN_LAST]});
    cls.at_flag    = (char_position inside {[tpp_pkg::FLAG_FIRST : tpp_pkg::FLAG_LAST]});
  end

endmodule
